/* src/tpba_pkg.sv */
package tpba_pkg;

   // atan(2^-i) in Q.24, one entry per rotation
   localparam int Iterations = 24;
   localparam int NormHigh = 20;
   localparam int ProdShift = 10;
   localparam int CordicPreshift = 20;
   localparam logic [24:0] HalfPiQ24 = 25'd26353589;
   localparam logic [17:0] PiQ16 = 18'd205887;

   // coordinate and difference widths
   localparam int CoordWidth = 32;
   localparam int DiffWidth = 33;
   // normalized component: magnitude below 2^20, signed
   localparam int NormWidth = 22;
   // product of two normalized components, and a sum of three
   localparam int ProdWidth = 42;
   localparam int SumWidth = 44;
   // scaled-down dot and cross values
   localparam int RedWidth = 34;
   // sum of three squares of cross components
   localparam int SqWidth = 68;
   localparam int RootWidth = 34;
   // cordic working width: root or dot up to 2^34, times 2^20, with growth
   localparam int CordWidth = 58;
   localparam int AngWidth = 27;

   function automatic logic [AngWidth-1:0] atan_q24(input logic [4:0] idx);
      logic [AngWidth-1:0] r;
      case (idx)
         5'd0: r = 27'd13176795;
         5'd1: r = 27'd7778716;
         5'd2: r = 27'd4110060;
         5'd3: r = 27'd2086331;
         5'd4: r = 27'd1047214;
         5'd5: r = 27'd524117;
         5'd6: r = 27'd262123;
         5'd7: r = 27'd131069;
         5'd8: r = 27'd65536;
         5'd9: r = 27'd32768;
         5'd10: r = 27'd16384;
         5'd11: r = 27'd8192;
         5'd12: r = 27'd4096;
         5'd13: r = 27'd2048;
         5'd14: r = 27'd1024;
         5'd15: r = 27'd512;
         5'd16: r = 27'd256;
         5'd17: r = 27'd128;
         5'd18: r = 27'd64;
         5'd19: r = 27'd32;
         5'd20: r = 27'd16;
         5'd21: r = 27'd8;
         5'd22: r = 27'd4;
         5'd23: r = 27'd2;
         default: r = '0;
      endcase
      return r;
   endfunction

   // truncate-toward-zero right shift of a signed value by ProdShift
   function automatic logic signed [RedWidth-1:0] shr_tz_sum(
      input logic signed [SumWidth-1:0] v);
      logic [SumWidth-1:0] m;
      logic [SumWidth-1:0] q;
      logic signed [RedWidth-1:0] r;
      m = v[SumWidth-1] ? SumWidth'(-v) : SumWidth'(v);
      q = m >> ProdShift;
      r = v[SumWidth-1] ? -RedWidth'(q) : RedWidth'(q);
      return r;
   endfunction

endpackage

/* src/tpba_norm.sv */
// difference and normalization of one vector, two register stages
module tpba_norm (
   input  logic                                      clock,
   input  logic                                      adv,
   input  logic signed [tpba_pkg::CoordWidth-1:0]    p_x,
   input  logic signed [tpba_pkg::CoordWidth-1:0]    p_y,
   input  logic signed [tpba_pkg::CoordWidth-1:0]    p_z,
   input  logic signed [tpba_pkg::CoordWidth-1:0]    v_x,
   input  logic signed [tpba_pkg::CoordWidth-1:0]    v_y,
   input  logic signed [tpba_pkg::CoordWidth-1:0]    v_z,
   output logic signed [tpba_pkg::NormWidth-1:0]     n_x,
   output logic signed [tpba_pkg::NormWidth-1:0]     n_y,
   output logic signed [tpba_pkg::NormWidth-1:0]     n_z,
   output logic                                      zero
);
   localparam int DW = tpba_pkg::DiffWidth;
   localparam int NW = tpba_pkg::NormWidth;

   logic signed [DW-1:0] d_ff [3];
   logic signed [DW-1:0] d_in [3];
   logic [DW-1:0] mag_ff [3];
   logic [DW-1:0] mag_in [3];
   logic [DW-1:0] m_all;
   logic [5:0] lead;
   logic signed [NW-1:0] n_ff [3];
   logic signed [NW-1:0] n_in [3];
   logic zero_ff;
   logic zero_in;

   // stage one: exact differences and magnitudes
   always_comb begin
      d_in[0] = DW'(p_x) - DW'(v_x);
      d_in[1] = DW'(p_y) - DW'(v_y);
      d_in[2] = DW'(p_z) - DW'(v_z);
      for (int k = 0; k < 3; k++) begin
         mag_in[k] = d_in[k][DW-1] ? DW'(-d_in[k]) : DW'(d_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= d_in;
         mag_ff <= mag_in;
      end
   end

   // stage two: leading one of the largest magnitude, then shift
   always_comb begin
      m_all = mag_ff[0] | mag_ff[1] | mag_ff[2];
      lead = '0;
      for (int b = 0; b < DW; b++) begin
         if (m_all[b]) lead = 6'(b);
      end
      zero_in = (m_all == '0);
      for (int k = 0; k < 3; k++) begin
         if (lead >= 6'(tpba_pkg::NormHigh)) begin
            n_in[k] = d_ff[k][DW-1]
               ? -NW'(mag_ff[k] >> (lead - 6'(tpba_pkg::NormHigh - 1)))
               : NW'(mag_ff[k] >> (lead - 6'(tpba_pkg::NormHigh - 1)));
         end else begin
            n_in[k] = NW'(d_ff[k]) <<< (6'(tpba_pkg::NormHigh - 1) - lead);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff <= n_in;
         zero_ff <= zero_in;
      end
   end

   assign n_x = n_ff[0];
   assign n_y = n_ff[1];
   assign n_z = n_ff[2];
   assign zero = zero_ff;
endmodule

/* src/tpba_prod.sv */
// dot and cross products, reduction and square root, pipelined
module tpba_prod (
   input  logic                                   clock,
   input  logic                                   adv,
   input  logic signed [tpba_pkg::NormWidth-1:0]  a [3],
   input  logic signed [tpba_pkg::NormWidth-1:0]  b [3],
   output logic signed [tpba_pkg::RedWidth-1:0]   dot_red,
   output logic [tpba_pkg::RootWidth-1:0]         cross_norm
);
   localparam int PW = tpba_pkg::ProdWidth;
   localparam int SW = tpba_pkg::SumWidth;
   localparam int RW = tpba_pkg::RedWidth;
   localparam int QW = tpba_pkg::SqWidth;
   localparam int TW = tpba_pkg::RootWidth;
   localparam int RootSteps = TW;
   localparam int StepsPerStage = 4;
   localparam int RootStages = (RootSteps + StepsPerStage - 1) / StepsPerStage;

   logic signed [PW-1:0] pr_ff [9];
   logic signed [PW-1:0] pr_in [9];
   logic signed [RW-1:0] red_ff [4];
   logic signed [RW-1:0] red_in [4];
   logic [RW-1:0] cm_ff [3];
   logic [RW-1:0] cm_in [3];
   logic signed [RW-1:0] dot_ff;
   logic [QW-1:0] sq_ff;
   logic [QW-1:0] sq_in;

   // products, one multiplier each
   always_comb begin
      pr_in[0] = PW'(a[0]) * PW'(b[0]);
      pr_in[1] = PW'(a[1]) * PW'(b[1]);
      pr_in[2] = PW'(a[2]) * PW'(b[2]);
      pr_in[3] = PW'(a[1]) * PW'(b[2]);
      pr_in[4] = PW'(a[2]) * PW'(b[1]);
      pr_in[5] = PW'(a[2]) * PW'(b[0]);
      pr_in[6] = PW'(a[0]) * PW'(b[2]);
      pr_in[7] = PW'(a[0]) * PW'(b[1]);
      pr_in[8] = PW'(a[1]) * PW'(b[0]);
   end

   always_ff @(posedge clock) begin
      if (adv) pr_ff <= pr_in;
   end

   // sums and truncating shift
   always_comb begin
      red_in[0] = tpba_pkg::shr_tz_sum(SW'(pr_ff[0]) + SW'(pr_ff[1]) + SW'(pr_ff[2]));
      red_in[1] = tpba_pkg::shr_tz_sum(SW'(pr_ff[3]) - SW'(pr_ff[4]));
      red_in[2] = tpba_pkg::shr_tz_sum(SW'(pr_ff[5]) - SW'(pr_ff[6]));
      red_in[3] = tpba_pkg::shr_tz_sum(SW'(pr_ff[7]) - SW'(pr_ff[8]));
   end

   always_ff @(posedge clock) begin
      if (adv) red_ff <= red_in;
   end

   // cross magnitudes
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cm_in[k] = red_ff[k+1][RW-1] ? RW'(-red_ff[k+1]) : RW'(red_ff[k+1]);
      end
   end

   logic signed [RW-1:0] dot_m;
   always_ff @(posedge clock) begin
      if (adv) begin
         cm_ff <= cm_in;
         dot_m <= red_ff[0];
      end
   end

   // squares, one multiplier each, then sum
   logic [QW-1:0] sqk_ff [3];
   logic [QW-1:0] sqk_in [3];
   always_comb begin
      for (int k = 0; k < 3; k++) sqk_in[k] = QW'(cm_ff[k]) * QW'(cm_ff[k]);
   end
   logic signed [RW-1:0] dot_s;
   always_ff @(posedge clock) begin
      if (adv) begin
         sqk_ff <= sqk_in;
         dot_s <= dot_m;
      end
   end

   assign sq_in = sqk_ff[0] + sqk_ff[1] + sqk_ff[2];
   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff <= sq_in;
         dot_ff <= dot_s;
      end
   end

   // restoring square root, a few result bits per stage
   logic [QW-1:0] rem_ff [RootStages+1];
   logic [TW-1:0] root_ff [RootStages+1];
   logic [QW-1:0] rad_ff [RootStages+1];
   logic signed [RW-1:0] rdot_ff [RootStages+1];

   assign rem_ff[0] = '0;
   assign root_ff[0] = '0;
   assign rad_ff[0] = sq_ff;
   assign rdot_ff[0] = dot_ff;

   for (genvar g = 0; g < RootStages; g++) begin : g_root
      logic [QW-1:0] rem_c;
      logic [TW-1:0] root_c;
      logic [QW-1:0] rad_c;
      logic [QW+1:0] trial;
      always_comb begin
         rem_c = rem_ff[g];
         root_c = root_ff[g];
         rad_c = rad_ff[g];
         trial = '0;
         for (int j = 0; j < StepsPerStage; j++) begin
            if (g * StepsPerStage + j < RootSteps) begin
               trial = {rem_c, rad_c[QW-1 -: 2]} - {(QW + 2 - TW - 2)'(0), root_c, 2'b01};
               if (!trial[QW+1]) begin
                  rem_c = trial[QW-1:0];
                  root_c = {root_c[TW-2:0], 1'b1};
               end else begin
                  rem_c = {rem_c[QW-3:0], rad_c[QW-1 -: 2]};
                  root_c = {root_c[TW-2:0], 1'b0};
               end
               rad_c = rad_c << 2;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g+1] <= rem_c;
            root_ff[g+1] <= root_c;
            rad_ff[g+1] <= rad_c;
            rdot_ff[g+1] <= rdot_ff[g];
         end
      end
   end

   assign dot_red = rdot_ff[RootStages];
   assign cross_norm = root_ff[RootStages];
endmodule

/* src/tpba_cordic.sv */
// vectoring cordic, a few rotations per stage, with rounding and clamp
module tpba_cordic (
   input  logic                                   clock,
   input  logic                                   adv,
   input  logic signed [tpba_pkg::RedWidth-1:0]   dot_red,
   input  logic [tpba_pkg::RootWidth-1:0]         cross_norm,
   output logic [17:0]                            angle
);
   localparam int CW = tpba_pkg::CordWidth;
   localparam int AW = tpba_pkg::AngWidth;
   localparam int Iters = tpba_pkg::Iterations;
   localparam int PerStage = 4;
   localparam int Stages = Iters / PerStage;

   logic signed [CW-1:0] x_ff [Stages+1];
   logic signed [CW-1:0] y_ff [Stages+1];
   logic signed [AW-1:0] z_ff [Stages+1];
   logic signed [CW-1:0] x_in;
   logic signed [CW-1:0] y_in;
   logic signed [AW-1:0] z_in;

   // quadrant fold and prescale
   always_comb begin
      if (dot_red[tpba_pkg::RedWidth-1]) begin
         x_in = CW'(signed'({1'b0, cross_norm})) <<< tpba_pkg::CordicPreshift;
         y_in = (-CW'(dot_red)) <<< tpba_pkg::CordicPreshift;
         z_in = AW'(tpba_pkg::HalfPiQ24);
      end else begin
         x_in = CW'(dot_red) <<< tpba_pkg::CordicPreshift;
         y_in = CW'(signed'({1'b0, cross_norm})) <<< tpba_pkg::CordicPreshift;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0] <= x_in;
         y_ff[0] <= y_in;
         z_ff[0] <= z_in;
      end
   end

   for (genvar g = 0; g < Stages; g++) begin : g_stage
      logic signed [CW-1:0] xc;
      logic signed [CW-1:0] yc;
      logic signed [AW-1:0] zc;
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      always_comb begin
         xc = x_ff[g];
         yc = y_ff[g];
         zc = z_ff[g];
         for (int j = 0; j < PerStage; j++) begin
            xs = xc >>> (g * PerStage + j);
            ys = yc >>> (g * PerStage + j);
            if (!yc[CW-1]) begin
               xc = xc + ys;
               yc = yc - xs;
               zc = zc + AW'(tpba_pkg::atan_q24(5'(g * PerStage + j)));
            end else begin
               xc = xc - ys;
               yc = yc + xs;
               zc = zc - AW'(tpba_pkg::atan_q24(5'(g * PerStage + j)));
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[g+1] <= xc;
            y_ff[g+1] <= yc;
            z_ff[g+1] <= zc;
         end
      end
   end

   // round half up, clamp to [0, pi]
   logic signed [AW-1:0] zr;
   logic [AW-1:0] zq;
   always_comb begin
      zr = z_ff[Stages] + AW'(128);
      zq = AW'(zr) >> 8;
      if (zr[AW-1]) angle = '0;
      else if (zq > AW'(tpba_pkg::PiQ16)) angle = tpba_pkg::PiQ16;
      else angle = zq[17:0];
   end
endmodule

/* src/three_point_bond_angle_unit.sv */
// channel   direction  ports
// request   in         req_valid, req_ready, req_end_a_*, req_vertex_*, req_end_b_*
// response  out        rsp_valid, rsp_ready, rsp_angle_rad, rsp_degenerate
//
// pipeline stages: 2 normalize, 5 product, 9 square root, 7 cordic stages
// (one fold, six of four rotations each); one transaction per cycle sustained
// while responses are taken.
// reset clears the valid bits of the whole pipeline.
// the pipeline advances as one while the output register is empty or taken,
// so a stall freezes every stage and nothing is lost or repeated.
module three_point_bond_angle_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [31:0]  req_end_a_x,
   input  logic [31:0]  req_end_a_y,
   input  logic [31:0]  req_end_a_z,
   input  logic [31:0]  req_vertex_x,
   input  logic [31:0]  req_vertex_y,
   input  logic [31:0]  req_vertex_z,
   input  logic [31:0]  req_end_b_x,
   input  logic [31:0]  req_end_b_y,
   input  logic [31:0]  req_end_b_z,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [17:0]  rsp_angle_rad,
   output logic         rsp_degenerate
);
   localparam int Depth = 2 + 4 + 1 + 9 + 7;

   logic adv;
   logic [Depth-1:0] vld_ff;
   logic [Depth-1:0] deg_ff;
   logic signed [tpba_pkg::NormWidth-1:0] na [3];
   logic signed [tpba_pkg::NormWidth-1:0] nb [3];
   logic za;
   logic zb;
   logic signed [tpba_pkg::RedWidth-1:0] dot_red;
   logic [tpba_pkg::RootWidth-1:0] cross_norm;
   logic [17:0] angle;

   // whole pipeline moves while the last stage can drain
   assign adv = !vld_ff[Depth-1] || rsp_ready;
   assign req_ready = adv;

   tpba_norm u_norm_a (
      .clock(clock), .adv(adv),
      .p_x(signed'(req_end_a_x)), .p_y(signed'(req_end_a_y)), .p_z(signed'(req_end_a_z)),
      .v_x(signed'(req_vertex_x)), .v_y(signed'(req_vertex_y)),
      .v_z(signed'(req_vertex_z)),
      .n_x(na[0]), .n_y(na[1]), .n_z(na[2]), .zero(za)
   );

   tpba_norm u_norm_b (
      .clock(clock), .adv(adv),
      .p_x(signed'(req_end_b_x)), .p_y(signed'(req_end_b_y)), .p_z(signed'(req_end_b_z)),
      .v_x(signed'(req_vertex_x)), .v_y(signed'(req_vertex_y)),
      .v_z(signed'(req_vertex_z)),
      .n_x(nb[0]), .n_y(nb[1]), .n_z(nb[2]), .zero(zb)
   );

   tpba_prod u_prod (
      .clock(clock), .adv(adv), .a(na), .b(nb),
      .dot_red(dot_red), .cross_norm(cross_norm)
   );

   tpba_cordic u_cordic (
      .clock(clock), .adv(adv), .dot_red(dot_red), .cross_norm(cross_norm),
      .angle(angle)
   );

   // valid and degenerate flags ride alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) deg_ff <= {deg_ff[Depth-2:0], 1'b0} | (Depth'(za || zb) << 2);
   end

   assign rsp_valid = vld_ff[Depth-1];
   assign rsp_degenerate = deg_ff[Depth-1];
   assign rsp_angle_rad = deg_ff[Depth-1] ? '0 : angle;
endmodule

/* verif/three_point_bond_angle_unit_tb.sv */
`timescale 1ns / 100ps

module three_point_bond_angle_unit_tb;

   localparam int WatchdogLimit = 4000;
   localparam int DrainCycles = 40;

   typedef struct packed {
      logic [17:0] angle;
      logic        degen;
   } angle_result_type;

   typedef logic [tpba_pkg::CoordWidth-1:0] coord_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   coord_type    req_end_a_x, req_end_a_y, req_end_a_z;
   coord_type    req_vertex_x, req_vertex_y, req_vertex_z;
   coord_type    req_end_b_x, req_end_b_y, req_end_b_z;
   logic         rsp_valid;
   logic         rsp_ready;
   logic [17:0]  rsp_angle_rad;
   logic         rsp_degenerate;

   angle_result_type angle_expect_q[$];
   int mismatches;
   int burst_left;
   int idle_cycles;
   int stall_phase;
   bit failed;

   three_point_bond_angle_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_end_a_x(req_end_a_x), .req_end_a_y(req_end_a_y), .req_end_a_z(req_end_a_z),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_vertex_z(req_vertex_z),
      .req_end_b_x(req_end_b_x), .req_end_b_y(req_end_b_y), .req_end_b_z(req_end_b_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_angle_rad(rsp_angle_rad), .rsp_degenerate(rsp_degenerate)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // truncate toward zero
   function automatic longint shift_trunc(input longint v, input int s);
      if (v < 0) return -((-v) >>> s);
      return v >>> s;
   endfunction

   function automatic longint abs_val(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // scale one vector so the largest magnitude lands in [2^19, 2^20)
   function automatic void scale_vector(inout longint v0, inout longint v1,
                                        inout longint v2);
      longint m;
      int s;
      m = abs_val(v0);
      s = 0;
      if (abs_val(v1) > m) m = abs_val(v1);
      if (abs_val(v2) > m) m = abs_val(v2);
      if (m >= (longint'(1) << tpba_pkg::NormHigh)) begin
         while ((m >>> s) >= (longint'(1) << tpba_pkg::NormHigh)) s++;
         v0 = shift_trunc(v0, s);
         v1 = shift_trunc(v1, s);
         v2 = shift_trunc(v2, s);
      end else begin
         while ((m << s) < (longint'(1) << (tpba_pkg::NormHigh - 1))) s++;
         v0 = v0 <<< s;
         v1 = v1 <<< s;
         v2 = v2 <<< s;
      end
   endfunction

   function automatic longint floor_sqrt(input logic [67:0] n);
      logic [67:0] res;
      logic [67:0] bitv;
      res = '0;
      bitv = 68'd1 << 66;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(res);
   endfunction

   // expected angle at the vertex for one transaction
   function automatic angle_result_type predict_bond_angle(
      input coord_type ax, input coord_type ay, input coord_type az,
      input coord_type vx, input coord_type vy, input coord_type vz,
      input coord_type bx, input coord_type by, input coord_type bz);
      angle_result_type r;
      longint d1x, d1y, d1z, d2x, d2y, d2z;
      longint dot, cx, cy, cz, t, x, y, z, xs, ys, nx;
      logic [67:0] sq;
      d1x = longint'($signed(ax)) - longint'($signed(vx));
      d1y = longint'($signed(ay)) - longint'($signed(vy));
      d1z = longint'($signed(az)) - longint'($signed(vz));
      d2x = longint'($signed(bx)) - longint'($signed(vx));
      d2y = longint'($signed(by)) - longint'($signed(vy));
      d2z = longint'($signed(bz)) - longint'($signed(vz));
      if ((d1x == 0 && d1y == 0 && d1z == 0) || (d2x == 0 && d2y == 0 && d2z == 0)) begin
         r.angle = '0;
         r.degen = 1'b1;
         return r;
      end
      scale_vector(d1x, d1y, d1z);
      scale_vector(d2x, d2y, d2z);
      dot = d1x * d2x + d1y * d2y + d1z * d2z;
      cx = d1y * d2z - d1z * d2y;
      cy = d1z * d2x - d1x * d2z;
      cz = d1x * d2y - d1y * d2x;
      sq = '0;
      t = abs_val(shift_trunc(cx, tpba_pkg::ProdShift));
      sq = sq + 68'(t) * 68'(t);
      t = abs_val(shift_trunc(cy, tpba_pkg::ProdShift));
      sq = sq + 68'(t) * 68'(t);
      t = abs_val(shift_trunc(cz, tpba_pkg::ProdShift));
      sq = sq + 68'(t) * 68'(t);
      x = shift_trunc(dot, tpba_pkg::ProdShift);
      y = floor_sqrt(sq);
      z = 0;
      // fold an obtuse angle into the right half plane
      if (x < 0) begin
         nx = y;
         y = -x;
         x = nx;
         z = longint'(tpba_pkg::HalfPiQ24);
      end
      x = x <<< tpba_pkg::CordicPreshift;
      y = y <<< tpba_pkg::CordicPreshift;
      for (int i = 0; i < tpba_pkg::Iterations; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(tpba_pkg::atan_q24(5'(i)));
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(tpba_pkg::atan_q24(5'(i)));
         end
      end
      z = z + 128;
      if (z < 0) z = 0;
      z = z >>> 8;
      if (z > longint'(tpba_pkg::PiQ16)) z = longint'(tpba_pkg::PiQ16);
      r.angle = 18'(z);
      r.degen = 1'b0;
      return r;
   endfunction

   // send one transaction, idling between bursts
   task automatic send_triple(input coord_type ax, input coord_type ay, input coord_type az,
                              input coord_type vx, input coord_type vy, input coord_type vz,
                              input coord_type bx, input coord_type by, input coord_type bz);
      int gap;
      req_valid <= 1'b1;
      req_end_a_x <= ax; req_end_a_y <= ay; req_end_a_z <= az;
      req_vertex_x <= vx; req_vertex_y <= vy; req_vertex_z <= vz;
      req_end_b_x <= bx; req_end_b_y <= by; req_end_b_z <= bz;
      do @(posedge clock); while (!req_ready);
      angle_expect_q.push_back(predict_bond_angle(ax, ay, az, vx, vy, vz, bx, by, bz));
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
   endtask

   // response checker and receiver stall pattern
   always @(posedge clock) begin
      angle_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_phase <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (angle_expect_q.size() == 0) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response angle=%0d degen=%0b",
                           rsp_angle_rad, rsp_degenerate);
            end else begin
               want = angle_expect_q.pop_front();
               if (want.angle !== rsp_angle_rad || want.degen !== rsp_degenerate) begin
                  failed = 1'b1;
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected angle=%0d degen=%0b got angle=%0d degen=%0b",
                              want.angle, want.degen, rsp_angle_rad, rsp_degenerate);
               end
            end
         end
         // stretches of full throughput alternate with random stalls
         stall_phase <= (stall_phase + 1) % 300;
         if (stall_phase < 100) rsp_ready <= 1'b1;
         else if (stall_phase < 200) rsp_ready <= ($urandom_range(0, 3) != 0);
         else rsp_ready <= ($urandom_range(0, 1) != 0);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic test_degenerate();
      send_triple(32'd5, 32'd6, 32'd7, 32'd5, 32'd6, 32'd7, 32'd1, 32'd2, 32'd3);
      send_triple(32'd1, 32'd2, 32'd3, 32'd9, 32'd9, 32'd9, 32'd9, 32'd9, 32'd9);
      send_triple('0, '0, '0, '0, '0, '0, '0, '0, '0);
      send_triple(32'h8000_0000, 32'h7fff_ffff, '0, 32'h8000_0000, 32'h7fff_ffff, '0,
                  '0, '0, '0);
   endtask

   task automatic test_extremes();
      send_triple(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_triple(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_triple(32'hffff_ffff, '0, '0, '0, '0, '0, '0, 32'd1, '0);
      send_triple(32'h7fff_ffff, '0, '0, 32'h8000_0000, '0, '0, '0, 32'h7fff_ffff, '0);
      send_triple(32'd1, 32'd1, 32'd1, '0, '0, '0, 32'hffff_ffff, 32'hffff_ffff, 32'd1);
   endtask

   task automatic test_known_angles();
      // right angle, acute, obtuse
      send_triple(32'h0001_0000, '0, '0, '0, '0, '0, '0, 32'h0001_0000, '0);
      send_triple(32'h0001_0000, '0, '0, '0, '0, '0,
                  32'h0001_0000, 32'h0001_0000, '0);
      send_triple(32'h0001_0000, '0, '0, '0, '0, '0,
                  32'hffff_0000, 32'h0001_0000, '0);
      send_triple(32'h0003_0000, 32'h0002_0000, 32'hfffe_0000, 32'h0001_0000, '0, '0,
                  32'hfff0_0000, 32'h0000_8000, 32'h0005_0000);
   endtask

   task automatic test_collinear();
      // same direction gives zero, opposite gives pi
      send_triple(32'd3, 32'd4, 32'd5, '0, '0, '0, 32'd300, 32'd400, 32'd500);
      send_triple(32'd3, 32'd4, 32'd5, '0, '0, '0, -32'sd3, -32'sd4, -32'sd5);
      send_triple(32'h1234_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h7fff_ffff, 32'h0, 32'h0);
      send_triple(32'h7fff_ffff, 32'h7fff_ffff, '0, '0, '0, '0,
                  32'h8000_0001, 32'h8000_0001, '0);
      send_triple(32'd1, '0, '0, '0, '0, '0, 32'hffff_ffff, '0, '0);
   endtask

   function automatic coord_type small_offset();
      int k;
      k = $urandom_range(0, 31);
      return coord_type'($urandom) >>> (31 - k) ^ ((($urandom & 1) != 0) ? '1 : '0);
   endfunction

   task automatic test_random(input int count);
      coord_type c[9];
      coord_type ox, oy, oz;
      int kind, scale;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 9);
         for (int k = 0; k < 9; k++) c[k] = coord_type'($urandom);
         if (kind < 5) begin
            // ends within a random distance of the vertex
            for (int k = 0; k < 3; k++) begin
               c[k] = c[3 + k] + small_offset();
               c[6 + k] = c[3 + k] + small_offset();
            end
         end else if (kind < 7) begin
            // second end on the line through the first, either side
            ox = small_offset() >>> 8;
            oy = small_offset() >>> 8;
            oz = small_offset() >>> 8;
            scale = $urandom_range(1, 64);
            if ($urandom_range(0, 1) != 0) scale = -scale;
            c[0] = c[3] + ox; c[1] = c[4] + oy; c[2] = c[5] + oz;
            c[6] = c[3] + ox * scale; c[7] = c[4] + oy * scale; c[8] = c[5] + oz * scale;
         end else if (kind == 7) begin
            // one end on the vertex
            if ($urandom_range(0, 1) != 0) begin
               c[0] = c[3]; c[1] = c[4]; c[2] = c[5];
            end else begin
               c[6] = c[3]; c[7] = c[4]; c[8] = c[5];
            end
         end
         send_triple(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
      end
   endtask

   initial begin
      int waited;
      failed = 1'b0;
      mismatches = 0;
      burst_left = 8;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_end_a_x <= '0; req_end_a_y <= '0; req_end_a_z <= '0;
      req_vertex_x <= '0; req_vertex_y <= '0; req_vertex_z <= '0;
      req_end_b_x <= '0; req_end_b_y <= '0; req_end_b_z <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_degenerate();
      test_extremes();
      test_known_angles();
      test_collinear();
      test_random(1030);
      req_valid <= 1'b0;

      // drain the pipeline
      waited = 0;
      while (angle_expect_q.size() != 0 && waited < WatchdogLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (DrainCycles) @(posedge clock);
      if (angle_expect_q.size() != 0) begin
         failed = 1'b1;
         $display("%0d expected responses never arrived", angle_expect_q.size());
      end
      if (!failed) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
